### src/sws_pkg.sv
// Shared types and constants for the shell word splitter.
// Used by sws_front, sws_queue, sws_back and shell_word_splitter_top; no dependencies.
`default_nettype none
package sws_pkg;

	localparam int CharW = 8;
	localparam int MaxRes = 4;
	localparam int ResIdxW = $clog2(MaxRes);
	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);
	localparam int QCntW = $clog2(QDepth + 1);

	localparam logic [CharW-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CharW-1:0] CH_SQUOTE = 8'h27;
	localparam logic [CharW-1:0] CH_DQUOTE = 8'h22;
	localparam logic [CharW-1:0] CH_SPACE = 8'h20;
	localparam logic [CharW-1:0] CH_TAB = 8'h09;
	localparam logic [CharW-1:0] CH_LF = 8'h0A;
	localparam logic [CharW-1:0] CH_CR = 8'h0D;
	localparam logic [CharW-1:0] CH_DOLLAR = 8'h24;
	localparam logic [CharW-1:0] CH_BQUOTE = 8'h60;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_WORD_END = 2'd1,
		KIND_LINE_END = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [CharW-1:0] ch;
	} res_t;

	// One queue entry holds every result that one input word causes.
	typedef struct packed {
		res_t [MaxRes-1:0] res;
		logic [ResIdxW-1:0] last_idx;
	} entry_t;

	typedef struct packed {
		logic push;
		entry_t entry;
	} qwr_t;

	typedef struct packed {
		logic valid;
		entry_t entry;
	} qhead_t;

	function automatic logic is_blank(input logic [CharW-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic dq_escapable(input logic [CharW-1:0] c);
		return (c == CH_DQUOTE) || (c == CH_BSLASH) || (c == CH_DOLLAR) ||
			(c == CH_BQUOTE) || (c == CH_LF);
	endfunction

endpackage
`default_nettype wire

### src/sws_front.sv
// Front end: accepts input words, tracks quoting state and builds result groups.
// Depends on sws_pkg; feeds sws_queue.
`default_nettype none
module sws_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [sws_pkg::CharW-1:0] in_char,
	input wire logic in_last,
	input wire logic q_full,
	output sws_pkg::qwr_t qwr
);

	logic sq_q, dq_q, wo_q, ep_q;
	logic sq_n, dq_n, wo_n, ep_n;
	logic accept;
	logic handle;
	logic [sws_pkg::ResIdxW:0] cnt;
	sws_pkg::res_t [sws_pkg::MaxRes-1:0] res;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	always_comb begin
		sq_n = sq_q;
		dq_n = dq_q;
		wo_n = wo_q;
		ep_n = ep_q;
		handle = 1'b1;
		cnt = '0;
		res = '0;
		if (ep_q) begin
			ep_n = 1'b0;
			if (dq_q) begin
				if (sws_pkg::dq_escapable(in_char)) begin
					res[cnt[sws_pkg::ResIdxW-1:0]] = '{sws_pkg::KIND_CHAR, in_char};
					cnt = cnt + 1'b1;
					handle = 1'b0;
				end else begin
					res[cnt[sws_pkg::ResIdxW-1:0]] = '{sws_pkg::KIND_CHAR, sws_pkg::CH_BSLASH};
					cnt = cnt + 1'b1;
				end
			end else begin
				res[cnt[sws_pkg::ResIdxW-1:0]] = '{sws_pkg::KIND_CHAR, in_char};
				cnt = cnt + 1'b1;
				wo_n = 1'b1;
				handle = 1'b0;
			end
		end
		if (handle) begin
			priority if (in_char == sws_pkg::CH_BSLASH) begin
				if (sq_q || (dq_q && in_last)) begin
					res[cnt[sws_pkg::ResIdxW-1:0]] = '{sws_pkg::KIND_CHAR, in_char};
					cnt = cnt + 1'b1;
				end else if (!in_last) begin
					ep_n = 1'b1;
				end
			end else if (in_char == sws_pkg::CH_SQUOTE) begin
				if (!dq_q) begin
					sq_n = !sq_q;
					wo_n = 1'b1;
				end else begin
					res[cnt[sws_pkg::ResIdxW-1:0]] = '{sws_pkg::KIND_CHAR, in_char};
					cnt = cnt + 1'b1;
				end
			end else if (in_char == sws_pkg::CH_DQUOTE) begin
				if (!sq_q) begin
					dq_n = !dq_q;
					wo_n = 1'b1;
				end else begin
					res[cnt[sws_pkg::ResIdxW-1:0]] = '{sws_pkg::KIND_CHAR, in_char};
					cnt = cnt + 1'b1;
				end
			end else if (sws_pkg::is_blank(in_char)) begin
				if (sq_q || dq_q) begin
					res[cnt[sws_pkg::ResIdxW-1:0]] = '{sws_pkg::KIND_CHAR, in_char};
					cnt = cnt + 1'b1;
				end else if (wo_n) begin
					res[cnt[sws_pkg::ResIdxW-1:0]] = '{sws_pkg::KIND_WORD_END, '0};
					cnt = cnt + 1'b1;
					wo_n = 1'b0;
				end
			end else begin
				res[cnt[sws_pkg::ResIdxW-1:0]] = '{sws_pkg::KIND_CHAR, in_char};
				cnt = cnt + 1'b1;
				wo_n = 1'b1;
			end
		end
		if (in_last) begin
			if (wo_n) begin
				res[cnt[sws_pkg::ResIdxW-1:0]] = '{sws_pkg::KIND_WORD_END, '0};
				cnt = cnt + 1'b1;
			end
			res[cnt[sws_pkg::ResIdxW-1:0]] = '{sws_pkg::KIND_LINE_END, '0};
			cnt = cnt + 1'b1;
			sq_n = 1'b0;
			dq_n = 1'b0;
			wo_n = 1'b0;
			ep_n = 1'b0;
		end
	end

	always_comb begin
		qwr.push = accept && (cnt != '0);
		qwr.entry.res = res;
		qwr.entry.last_idx = sws_pkg::ResIdxW'(cnt - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q <= 1'b0;
			dq_q <= 1'b0;
			wo_q <= 1'b0;
			ep_q <= 1'b0;
		end else if (accept) begin
			sq_q <= sq_n;
			dq_q <= dq_n;
			wo_q <= wo_n;
			ep_q <= ep_n;
		end
	end

	a_esc_not_in_sq: assert property (@(posedge clk) disable iff (!arst_n)
		!(ep_q && sq_q)) else $error("escape pending inside single quotes");
	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |=> (!sq_q && !dq_q && !wo_q && !ep_q))
		else $error("state not cleared after line end");

endmodule
`default_nettype wire

### src/sws_queue.sv
// Four-entry queue of result groups between the front end and the serializer.
// Depends on sws_pkg.
`default_nettype none
module sws_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire sws_pkg::qwr_t qwr,
	output logic full,
	input wire logic pop,
	output sws_pkg::qhead_t head
);

	sws_pkg::entry_t mem_q [sws_pkg::QDepth];
	logic [sws_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [sws_pkg::QCntW-1:0] cnt_q;
	logic wr, rd;

	assign full = (cnt_q == sws_pkg::QCntW'(sws_pkg::QDepth));
	assign wr = qwr.push && !full;
	assign rd = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= qwr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + sws_pkg::QCntW'(wr) - sws_pkg::QCntW'(rd);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sws_pkg::QCntW'(sws_pkg::QDepth)) else $error("queue count overflow");

endmodule
`default_nettype wire

### src/sws_back.sv
// Back end: walks each queued result group and drives the output register.
// Depends on sws_pkg; reads the head of sws_queue.
`default_nettype none
module sws_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire sws_pkg::qhead_t head,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output sws_pkg::kind_t out_kind,
	output logic [sws_pkg::CharW-1:0] out_char,
	output logic out_last
);

	logic [sws_pkg::ResIdxW-1:0] idx_q;
	logic valid_q;
	logic load;
	logic at_end;
	sws_pkg::res_t cur;

	assign cur = head.entry.res[idx_q];
	assign at_end = (idx_q == head.entry.last_idx);
	assign load = head.valid && (!valid_q || out_ready);
	assign pop = load && at_end;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= at_end ? '0 : idx_q + 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind <= cur.kind;
			out_char <= cur.ch;
			out_last <= at_end;
		end
	end

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> (idx_q <= head.entry.last_idx))
		else $error("result index past end of group");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> (valid_q && $stable(out_kind) && $stable(out_char)))
		else $error("stalled result changed");

endmodule
`default_nettype wire

### src/shell_word_splitter_top.sv
// Top level of the shell word splitter: front end, result queue and serializer.
// Depends on sws_pkg, sws_front, sws_queue and sws_back.
//
// Channel  Dir  tdata            tuser    tlast
// s_axis   in   char_in[7:0]     -        last
// m_axis   out  char_out[7:0]    kind[1:0] last_of_run
//
// Each input word goes through the front end and yields zero to four results.
// While m_axis_tready is high the serializer sends one result per cycle, so the
// rate is one input word per cycle while words yield at most one result each;
// larger result groups hold the output longer; the four-entry queue absorbs that.
// Reset clears the quoting state, the queue pointers and the output valid.
// s_axis_tready falls only when the queue is full.
`default_nettype none
module shell_word_splitter_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata, // [7:0] char_in
	input wire logic s_axis_tlast,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [7:0] m_axis_tdata, // [7:0] char_out
	output logic [1:0] m_axis_tuser, // [1:0] kind
	output logic m_axis_tlast
);

	sws_pkg::qwr_t qwr;
	sws_pkg::qhead_t head;
	sws_pkg::kind_t out_kind;
	logic q_full;
	logic pop;

	sws_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_char(s_axis_tdata),
		.in_last(s_axis_tlast),
		.q_full(q_full),
		.qwr(qwr)
	);

	sws_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.qwr(qwr),
		.full(q_full),
		.pop(pop),
		.head(head)
	);

	sws_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_kind(out_kind),
		.out_char(m_axis_tdata),
		.out_last(m_axis_tlast)
	);

	assign m_axis_tuser = 2'(out_kind);

endmodule
`default_nettype wire

### verif/shell_word_splitter_top_tb.sv
// Self-checking testbench for shell_word_splitter_top: streams command lines byte by byte
// and compares each output word against a built-in model of shell word splitting.
// Depends on sws_pkg and the RTL under src.
`default_nettype none
module shell_word_splitter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [sws_pkg::CharW-1:0] ch;
		logic fin;
	} line_byte_t;

	typedef struct packed {
		sws_pkg::kind_t kind;
		logic [sws_pkg::CharW-1:0] ch;
		logic fin;
	} split_res_t;

	typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;

	line_byte_t line_bytes_q[$];
	split_res_t split_out_q[$];
	int err_cnt = 0;

	logic in_sq = 1'b0;
	logic in_dq = 1'b0;
	logic word_started = 1'b0;
	logic bs_pending = 1'b0;

	int burst_left = 0;
	int gap_left = 0;
	int rx_cyc = 0;
	int hold_left = 0;
	rx_mode_t rx_mode = RX_FREE;

	shell_word_splitter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void split_byte(input logic [sws_pkg::CharW-1:0] c, input logic lst);
		split_res_t outs[$];
		logic plain;
		plain = 1'b1;
		if (bs_pending) begin
			bs_pending = 1'b0;
			if (in_dq && !(c == sws_pkg::CH_DQUOTE || c == sws_pkg::CH_BSLASH ||
					c == sws_pkg::CH_DOLLAR || c == sws_pkg::CH_BQUOTE ||
					c == sws_pkg::CH_LF)) begin
				outs.push_back(split_res_t'{sws_pkg::KIND_CHAR, sws_pkg::CH_BSLASH, 1'b0});
			end else begin
				outs.push_back(split_res_t'{sws_pkg::KIND_CHAR, c, 1'b0});
				word_started = 1'b1;
				plain = 1'b0;
			end
		end
		if (plain) begin
			if (c == sws_pkg::CH_BSLASH) begin
				if (in_sq) begin
					outs.push_back(split_res_t'{sws_pkg::KIND_CHAR, c, 1'b0});
				end else if (lst) begin
					if (in_dq)
						outs.push_back(split_res_t'{sws_pkg::KIND_CHAR, c, 1'b0});
				end else begin
					bs_pending = 1'b1;
				end
			end else if (c == sws_pkg::CH_SQUOTE && !in_dq) begin
				in_sq = !in_sq;
				word_started = 1'b1;
			end else if (c == sws_pkg::CH_DQUOTE && !in_sq) begin
				in_dq = !in_dq;
				word_started = 1'b1;
			end else if ((c == sws_pkg::CH_SPACE || c == sws_pkg::CH_TAB ||
					c == sws_pkg::CH_LF || c == sws_pkg::CH_CR) && !in_sq && !in_dq) begin
				if (word_started)
					outs.push_back(split_res_t'{sws_pkg::KIND_WORD_END, 8'h00, 1'b0});
				word_started = 1'b0;
			end else begin
				outs.push_back(split_res_t'{sws_pkg::KIND_CHAR, c, 1'b0});
				word_started = 1'b1;
			end
		end
		if (lst) begin
			if (word_started)
				outs.push_back(split_res_t'{sws_pkg::KIND_WORD_END, 8'h00, 1'b0});
			outs.push_back(split_res_t'{sws_pkg::KIND_LINE_END, 8'h00, 1'b0});
			in_sq = 1'b0;
			in_dq = 1'b0;
			word_started = 1'b0;
			bs_pending = 1'b0;
		end
		if (outs.size() != 0)
			outs[outs.size() - 1].fin = 1'b1;
		foreach (outs[i])
			split_out_q.push_back(outs[i]);
	endfunction

	function automatic void add_byte(input logic [sws_pkg::CharW-1:0] c, input logic fin);
		line_bytes_q.push_back(line_byte_t'{c, fin});
	endfunction

	function automatic void add_text(input string s, input logic close);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], close && (i == s.len() - 1));
	endfunction

	function automatic logic [sws_pkg::CharW-1:0] pick_byte();
		logic [sws_pkg::CharW-1:0] b;
		case ($urandom_range(0, 11))
			0: b = sws_pkg::CH_BSLASH;
			1: b = sws_pkg::CH_SQUOTE;
			2: b = sws_pkg::CH_DQUOTE;
			3: b = sws_pkg::CH_SPACE;
			4: b = ($urandom_range(0, 2) == 0) ? sws_pkg::CH_TAB :
				($urandom_range(0, 1) ? sws_pkg::CH_LF : sws_pkg::CH_CR);
			5: b = $urandom_range(0, 1) ? sws_pkg::CH_DOLLAR : sws_pkg::CH_BQUOTE;
			6, 7, 8: b = 8'h61 + 8'($urandom_range(0, 25));
			default: b = 8'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	always @(posedge clk) begin
		line_byte_t item;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!(s_axis_tvalid && !s_axis_tready)) begin
			if (gap_left != 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (line_bytes_q.size() != 0) begin
				item = line_bytes_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= item.ch;
				s_axis_tlast <= item.fin;
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 15);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// The receiver holds off for a long stretch now and then so the result queue fills up.
	always @(posedge clk) begin
		rx_cyc++;
		if (rx_cyc % 1200 == 100)
			hold_left = $urandom_range(100, 160);
		if (rx_cyc % 60 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE: m_axis_tready <= 1'b1;
				RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= (rx_cyc % 4 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		split_res_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				split_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (split_out_q.size() == 0) begin
					$display("%0t: unexpected word: kind %0d char %h last %b", $time,
						m_axis_tuser, m_axis_tdata, m_axis_tlast);
					err_cnt++;
				end else begin
					want = split_out_q.pop_front();
					if (m_axis_tuser != want.kind) begin
						$display("%0t: kind expected %0d actual %0d", $time, want.kind,
							m_axis_tuser);
						err_cnt++;
					end
					if (m_axis_tdata != want.ch) begin
						$display("%0t: char expected %h actual %h", $time, want.ch,
							m_axis_tdata);
						err_cnt++;
					end
					if (m_axis_tlast != want.fin) begin
						$display("%0t: last expected %b actual %b", $time, want.fin,
							m_axis_tlast);
						err_cnt++;
					end
				end
			end
		end
	end

	initial begin
		int n_rand;
		int len;
		logic noisy;
		// Double quotes: escapes, a kept backslash before a plain byte, a trailing backslash.
		add_text("\"\\q\\$\\\n' \\", 1'b1);
		// Single quotes, escaped blank outside, tab, LF and CR, extreme bytes, dropped backslash.
		add_text("'\\\"'\\ \t\n", 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(sws_pkg::CH_CR, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(sws_pkg::CH_BSLASH, 1'b1);
		add_text("''", 1'b1);
		add_text("\"\\z", 1'b1);
		add_text("\\", 1'b1);
		n_rand = 0;
		while (n_rand < 360) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			noisy = ($urandom_range(0, 5) == 0);
			for (int i = 0; i < len; i++)
				add_byte(noisy ? 8'($urandom_range(0, 255)) : pick_byte(), i == len - 1);
			n_rand += len;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		do @(negedge clk); while (line_bytes_q.size() != 0 || s_axis_tvalid);
		do @(negedge clk); while (split_out_q.size() != 0);
		repeat (20) @(negedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#1ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire

### shell_word_splitter_top.f
src/sws_pkg.sv
src/sws_front.sv
src/sws_queue.sv
src/sws_back.sv
src/shell_word_splitter_top.sv
verif/shell_word_splitter_top_tb.sv
